/* sv/assert_macros.svh */
// assertion macros used by the top rtl file of the min/max normalizer
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/swmn_pkg.sv */
// shared constants, types and state codes of the min/max normalizer
// no dependencies
`default_nettype none
package swmn_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SCORE_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
    localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int HEIGHT_BITS = 12;
    localparam int STEP_BITS   = $clog2(HEIGHT_BITS);
    localparam int ROW_BITS    = HEIGHT_BITS + 1;
    localparam int LEN_BITS    = 7;
    localparam int CFG_BITS    = 12;
    localparam int IDX_BITS    = 2;

    localparam logic [HEIGHT_BITS-1:0] MIN_HEIGHT = HEIGHT_BITS'(20);

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_WINDOW_LEN    = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_TOP_MARGIN    = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] REG_WIDGET_HEIGHT = IDX_BITS'(2);

    localparam logic [LEN_BITS-1:0]    RST_WINDOW_LEN    = LEN_BITS'(16);
    localparam logic [HEIGHT_BITS-1:0] RST_TOP_MARGIN    = HEIGHT_BITS'(10);
    localparam logic [HEIGHT_BITS-1:0] RST_WIDGET_HEIGHT = HEIGHT_BITS'(100);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } state_t;

    // operands of the scaled quotient floor(d * h / r), rd = r - d
    typedef struct packed {
        logic [SCORE_BITS-1:0]  d;
        logic [SCORE_BITS-1:0]  rd;
        logic [SCORE_BITS-1:0]  r;
        logic [HEIGHT_BITS-1:0] h;
    } div_req_t;

endpackage
`default_nettype wire

/* sv/sliding_window_minmax_normalizer.sv */
// Sliding-window min/max normalizer. Each accepted score word (unsigned
// Q24.8) is written into a 64-entry score memory, then the last
// min(scores seen, window_len) entries are read back one per cycle through
// the memory's single read port to find the window minimum and maximum.
// When max > min a serial divider computes floor((max - score) * height /
// (max - min)), a doubling step then an adding step per quotient bit, and
// the indicator row is top_margin plus that quotient; when max == min the
// row is top_margin + height / 2 and neutral is set. After acceptance an
// item passes through the scan, drain and calc states, then the divide
// state when max > min, and waits in the done state until the output
// register is free. Items are handled one at a time: in_stall is high from
// acceptance until the result is loaded into the output register, and a new
// score is taken while a finished result still waits there. The score
// memory needs no clearing pass, since only written entries are read.
// Configuration (window_len 0 acts as 1, above 64 acts as 64; widget_height
// below 20 acts as 20) must be written only while the block is idle; the
// block itself does not enforce this.
// depends on swmn_pkg, swmn_score_ram, swmn_divider, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module sliding_window_minmax_normalizer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_write,
    input  wire logic [swmn_pkg::IDX_BITS-1:0]   cfg_index,
    input  wire logic [swmn_pkg::CFG_BITS-1:0]   cfg_data,
    // input word channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [swmn_pkg::SCORE_BITS-1:0] score,
    // output word channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [swmn_pkg::SCORE_BITS-1:0] window_min,
    output logic      [swmn_pkg::SCORE_BITS-1:0] window_max,
    output logic      [swmn_pkg::ROW_BITS-1:0]   indicator_row,
    output logic                                 neutral
);

    localparam int SB = swmn_pkg::SCORE_BITS;
    localparam int AB = swmn_pkg::ADDR_BITS;
    localparam int CB = swmn_pkg::CNT_BITS;
    localparam int HB = swmn_pkg::HEIGHT_BITS;
    localparam int RB = swmn_pkg::ROW_BITS;
    localparam int LB = swmn_pkg::LEN_BITS;

    // configuration registers
    logic [LB-1:0] len_reg;
    logic [HB-1:0] margin_reg;
    logic [HB-1:0] height_reg;

    // control state
    swmn_pkg::state_t state_reg, state_next;
    logic [AB-1:0]    slot_reg;
    logic [CB-1:0]    fill_reg;
    logic [CB-1:0]    fill_next;
    logic [CB-1:0]    cnt_reg;
    logic [CB-1:0]    cnt_next;
    logic [CB-1:0]    k_reg;
    logic             rd_pend_reg;
    logic             out_valid_reg;

    // item datapath
    logic [SB-1:0] cur_reg;
    logic [SB-1:0] min_reg;
    logic [SB-1:0] max_reg;
    logic [HB-1:0] h_reg;
    logic [RB-1:0] row_reg;
    logic          neu_reg;

    // output word register
    logic [SB-1:0] out_min_reg;
    logic [SB-1:0] out_max_reg;
    logic [RB-1:0] out_row_reg;
    logic          out_neu_reg;

    // strobes from the sequencer
    logic in_fire;
    logic out_free;
    logic scan_issue;
    logic div_start;
    logic out_load;

    logic [CB-1:0]      len_eff;
    logic [AB-1:0]      rd_addr;
    logic [SB-1:0]      rd_data;
    swmn_pkg::div_req_t div_req;
    logic               div_done;
    logic [HB-1:0]      div_quot;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // effective window length clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = CB'(1);
        end
        else if (CB'(len_reg) > CB'(swmn_pkg::MAX_WINDOW))
        begin
            len_eff = CB'(swmn_pkg::MAX_WINDOW);
        end
        else
        begin
            len_eff = CB'(len_reg);
        end
    end

    // fill count saturates at the store depth; scan count is min(fill, len)
    assign fill_next = (fill_reg < CB'(swmn_pkg::MAX_WINDOW)) ? fill_reg + 1'b1 : fill_reg;
    assign cnt_next  = (fill_next < len_eff) ? fill_next : len_eff;

    // slot_reg already points past the newest score, so entry k back is slot - k
    assign rd_addr = slot_reg - k_reg[AB-1:0];

    // range below the top (max - cur), full range and cur - min for the divider
    assign div_req.d  = max_reg - cur_reg;
    assign div_req.rd = cur_reg - min_reg;
    assign div_req.r  = max_reg - min_reg;
    assign div_req.h  = h_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= swmn_pkg::RST_WINDOW_LEN;
            margin_reg <= swmn_pkg::RST_TOP_MARGIN;
            height_reg <= swmn_pkg::RST_WIDGET_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                swmn_pkg::REG_WINDOW_LEN:    len_reg    <= cfg_data[LB-1:0];
                swmn_pkg::REG_TOP_MARGIN:    margin_reg <= cfg_data[HB-1:0];
                swmn_pkg::REG_WIDGET_HEIGHT: height_reg <= cfg_data[HB-1:0];
                default:                     ;  // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        scan_issue = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            swmn_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = swmn_pkg::ST_SCAN;
                end
            end
            swmn_pkg::ST_SCAN:
            begin
                // one memory read per cycle, newest entry first
                scan_issue = 1'b1;
                if (k_reg == cnt_reg)
                begin
                    state_next = swmn_pkg::ST_DRAIN;
                end
            end
            swmn_pkg::ST_DRAIN:
            begin
                // last read data is folded in at this edge
                state_next = swmn_pkg::ST_CALC;
            end
            swmn_pkg::ST_CALC:
            begin
                if (max_reg > min_reg)
                begin
                    div_start  = 1'b1;
                    state_next = swmn_pkg::ST_DIV;
                end
                else
                begin
                    state_next = swmn_pkg::ST_DONE;
                end
            end
            swmn_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = swmn_pkg::ST_DONE;
                end
            end
            swmn_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = swmn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmn_pkg::ST_IDLE;
            end
        endcase
    end

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= scan_issue;
            if (in_fire)
            begin
                slot_reg <= slot_reg + 1'b1;
                fill_reg <= fill_next;
                cnt_reg  <= cnt_next;
                k_reg    <= CB'(1);
            end
            else if (scan_issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_reg <= score;
            min_reg <= score;
            max_reg <= score;
            h_reg   <= (height_reg < swmn_pkg::MIN_HEIGHT) ? swmn_pkg::MIN_HEIGHT
                                                           : height_reg;
        end
        else if (rd_pend_reg)
        begin
            if (rd_data < min_reg)
            begin
                min_reg <= rd_data;
            end
            if (rd_data > max_reg)
            begin
                max_reg <= rd_data;
            end
        end

        if (state_reg == swmn_pkg::ST_CALC && !(max_reg > min_reg))
        begin
            // flat window: middle row
            row_reg <= {1'b0, margin_reg} + RB'(h_reg >> 1);
            neu_reg <= 1'b1;
        end
        else if (state_reg == swmn_pkg::ST_DIV && div_done)
        begin
            row_reg <= {1'b0, margin_reg} + {1'b0, div_quot};
            neu_reg <= 1'b0;
        end

        if (out_load)
        begin
            out_min_reg <= min_reg;
            out_max_reg <= max_reg;
            out_row_reg <= row_reg;
            out_neu_reg <= neu_reg;
        end
    end

    // ------------------------------------------------------------------
    // score memory and divider
    // ------------------------------------------------------------------
    swmn_score_ram u_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (slot_reg),
        .wdata (score),
        .re    (scan_issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    swmn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid     = out_valid_reg;
    assign window_min    = out_min_reg;
    assign window_max    = out_max_reg;
    assign indicator_row = out_row_reg;
    assign neutral       = out_neu_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a finished result always lands in the output register
    `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, out_load, out_valid_reg)
    // no memory read is in flight once the sequencer is back to idle
    `ASSERT_IMPL(a_idle_no_read, clk, rst_n, state_reg == swmn_pkg::ST_IDLE, !rd_pend_reg)
    // when the divide starts the newest score lies inside the window range
    `ASSERT_IMPL(a_cur_in_range, clk, rst_n, div_start, min_reg <= cur_reg && cur_reg <= max_reg)
    // the scaled quotient never exceeds the widget height
    `ASSERT_IMPL(a_quot_bound, clk, rst_n, div_done, div_quot <= h_reg)

endmodule
`default_nettype wire

/* sv/swmn_score_ram.sv */
// score store: one write port, one read port, registered read data
// depends on swmn_pkg
`default_nettype none
module swmn_score_ram (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [swmn_pkg::ADDR_BITS-1:0]  waddr,
    input  wire logic [swmn_pkg::SCORE_BITS-1:0] wdata,
    input  wire logic                            re,
    input  wire logic [swmn_pkg::ADDR_BITS-1:0]  raddr,
    output logic      [swmn_pkg::SCORE_BITS-1:0] rdata
);

    logic [swmn_pkg::SCORE_BITS-1:0] mem [swmn_pkg::MAX_WINDOW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/swmn_divider.sv */
// serial scaled quotient floor(d * h / r), one half-step per cycle
// depends on swmn_pkg
`default_nettype none
module swmn_divider (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire swmn_pkg::div_req_t               req,
    output logic                                  done,
    output logic      [swmn_pkg::HEIGHT_BITS-1:0] quot
);

    localparam int SB = swmn_pkg::SCORE_BITS;
    localparam int HB = swmn_pkg::HEIGHT_BITS;

    swmn_pkg::div_req_t              req_reg;
    logic                            busy_reg;
    logic                            phase_reg;
    logic [swmn_pkg::STEP_BITS-1:0]  step_reg;
    logic [SB-1:0]                   rem_reg;
    logic [HB-1:0]                   quot_reg;
    logic                            done_reg;

    logic [SB+1:0] dbl_diff;
    logic [SB:0]   add_diff;

    // doubling: 2*rem - r, sign tells whether 2*rem >= r
    assign dbl_diff = {1'b0, rem_reg, 1'b0} - {2'b00, req_reg.r};
    // adding d: rem - (r - d), sign tells whether rem + d >= r
    assign add_diff = {1'b0, rem_reg} - {1'b0, req_reg.rd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                step_reg  <= swmn_pkg::STEP_BITS'(HB - 1);
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    if (step_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg  <= req;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                if (!dbl_diff[SB+1])
                begin
                    rem_reg  <= dbl_diff[SB-1:0];
                    quot_reg <= {quot_reg[HB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= {rem_reg[SB-2:0], 1'b0};
                    quot_reg <= {quot_reg[HB-2:0], 1'b0};
                end
            end
            else if (req_reg.h[step_reg])
            begin
                if (!add_diff[SB])
                begin
                    rem_reg  <= add_diff[SB-1:0];
                    quot_reg <= quot_reg + 1'b1;
                end
                else
                begin
                    rem_reg <= rem_reg + req_reg.d;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

/* tb/sv/tb_sliding_window_minmax_normalizer.sv */
// self-checking testbench for the sliding-window min/max normalizer
// drives score words and register writes, predicts every result word and compares
// depends on swmn_pkg and sliding_window_minmax_normalizer
`timescale 1ns / 1ps
module tb_sliding_window_minmax_normalizer;

    // index with no register behind it, writes there must be dropped
    localparam logic [swmn_pkg::IDX_BITS-1:0] REG_UNUSED = swmn_pkg::IDX_BITS'(3);

    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 96;
    localparam int SETTLE_CYCLES   = 4;
    // extra wait after the last result word
    localparam int DRAIN_CYCLES    = 120;
    // long receiver hold, and the stretch of words with no idling on either side
    localparam int HOLD_AT         = 250;
    localparam int HOLD_CYCLES     = 500;
    localparam int CALM_FROM       = 600;
    localparam int CALM_TO         = 760;
    // hold plus slowest item plus random stalls, taken several times over
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int LOG_LIMIT       = 100;
    // words in flight are few; the directed table is short
    localparam int FIFO_DEPTH      = 16;
    localparam int DIRECTED_MAX    = 64;

    // one result word as the block gives it
    typedef struct packed {
        logic [swmn_pkg::SCORE_BITS-1:0] lo;
        logic [swmn_pkg::SCORE_BITS-1:0] hi;
        logic [swmn_pkg::ROW_BITS-1:0]   row;
        logic                            flat;
    } result_t;

    // typed-in expectation that travels with a score word, if any
    typedef struct packed {
        logic    typed;
        result_t want;
    } preset_t;

    typedef enum logic {ROW_WRITE, ROW_SCORE} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [swmn_pkg::IDX_BITS-1:0]   reg_idx;
        logic [swmn_pkg::CFG_BITS-1:0]   reg_data;
        logic [swmn_pkg::SCORE_BITS-1:0] value;
        logic                            typed;
        result_t                         want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [swmn_pkg::IDX_BITS-1:0] cfg_index = '0;
    logic [swmn_pkg::CFG_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [swmn_pkg::SCORE_BITS-1:0] score = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [swmn_pkg::SCORE_BITS-1:0] window_min;
    logic [swmn_pkg::SCORE_BITS-1:0] window_max;
    logic [swmn_pkg::ROW_BITS-1:0] indicator_row;
    logic neutral;

    sliding_window_minmax_normalizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .score         (score),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_min    (window_min),
        .window_max    (window_max),
        .indicator_row (indicator_row),
        .neutral       (neutral)
    );

    always #5 clk = ~clk;

    // shadow of the block: score history, write pointer, fill count, registers
    logic [swmn_pkg::SCORE_BITS-1:0]  hist [swmn_pkg::MAX_WINDOW];
    logic [swmn_pkg::ADDR_BITS-1:0]   slot = '0;
    logic [swmn_pkg::CNT_BITS-1:0]    filled = '0;
    logic [swmn_pkg::LEN_BITS-1:0]    mdl_len = swmn_pkg::RST_WINDOW_LEN;
    logic [swmn_pkg::HEIGHT_BITS-1:0] mdl_margin = swmn_pkg::RST_TOP_MARGIN;
    logic [swmn_pkg::HEIGHT_BITS-1:0] mdl_height = swmn_pkg::RST_WIDGET_HEIGHT;

    // expected result words and presets, as ring buffers with running counts
    result_t exp_fifo [FIFO_DEPTH];
    int      exp_wr = 0;
    int      exp_rd = 0;
    preset_t preset_fifo [FIFO_DEPTH];
    int      preset_wr = 0;
    int      preset_rd = 0;
    row_t    directed [DIRECTED_MAX];
    int      directed_cnt = 0;
    int      errors = 0;
    int      sent = 0;

    // store the score, then scan the window and place the indicator row
    function automatic result_t next_window_result(
        input logic [swmn_pkg::SCORE_BITS-1:0] s);
        result_t res;
        int len;
        int count;
        int k;
        logic [swmn_pkg::SCORE_BITS-1:0] v;
        logic [swmn_pkg::HEIGHT_BITS-1:0] h;
        logic [63:0] quot;
        hist[slot] = s;
        slot = slot + 1'b1;
        if (filled < swmn_pkg::MAX_WINDOW)
            filled = filled + 1'b1;
        // zero length acts as one, anything past the store acts as the store
        len = (mdl_len == 0) ? 1 : (mdl_len > swmn_pkg::MAX_WINDOW) ? swmn_pkg::MAX_WINDOW
                                                                    : int'(mdl_len);
        count = (int'(filled) < len) ? int'(filled) : len;
        res.lo = s;
        res.hi = s;
        // older entries come back when the window grows again
        for (k = 1; k <= count; k++)
        begin
            v = hist[(int'(slot) - k + swmn_pkg::MAX_WINDOW) % swmn_pkg::MAX_WINDOW];
            if (v < res.lo)
                res.lo = v;
            if (v > res.hi)
                res.hi = v;
        end
        h = (mdl_height < swmn_pkg::MIN_HEIGHT) ? swmn_pkg::MIN_HEIGHT : mdl_height;
        if (res.hi > res.lo)
        begin
            // newest score is inside [lo, hi], so the quotient stays within h
            quot = (64'(res.hi - s) * 64'(h)) / 64'(res.hi - res.lo);
            res.row = swmn_pkg::ROW_BITS'(mdl_margin) + swmn_pkg::ROW_BITS'(quot);
            res.flat = 1'b0;
        end
        else
        begin
            // flat window: middle row and neutral flag
            res.row = swmn_pkg::ROW_BITS'(mdl_margin) + swmn_pkg::ROW_BITS'(h >> 1);
            res.flat = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [swmn_pkg::SCORE_BITS-1:0] got,
                                   input logic [swmn_pkg::SCORE_BITS-1:0] want);
        // keep the log short when everything goes wrong
        if (errors < LOG_LIMIT)
            $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
        errors++;
    endtask

    // monitor: check result words, predict accepted score words, track writes
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t model;
        preset_t pre;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{window_min, window_max, indicator_row, neutral};
                if (exp_wr == exp_rd)
                    report_mismatch("result word with nothing pending", got.lo, '0);
                else
                begin
                    want = exp_fifo[exp_rd % FIFO_DEPTH];
                    exp_rd++;
                    if (got.lo !== want.lo)
                        report_mismatch("window_min", got.lo, want.lo);
                    if (got.hi !== want.hi)
                        report_mismatch("window_max", got.hi, want.hi);
                    if (got.row !== want.row)
                        report_mismatch("indicator_row", swmn_pkg::SCORE_BITS'(got.row),
                                        swmn_pkg::SCORE_BITS'(want.row));
                    if (got.flat !== want.flat)
                        report_mismatch("neutral", swmn_pkg::SCORE_BITS'(got.flat),
                                        swmn_pkg::SCORE_BITS'(want.flat));
                end
            end
            if (in_valid && !in_stall)
            begin
                model = next_window_result(score);
                pre = preset_fifo[preset_rd % FIFO_DEPTH];
                preset_rd++;
                exp_fifo[exp_wr % FIFO_DEPTH] = pre.typed ? pre.want : model;
                exp_wr++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    swmn_pkg::REG_WINDOW_LEN:
                        mdl_len = cfg_data[swmn_pkg::LEN_BITS-1:0];
                    swmn_pkg::REG_TOP_MARGIN:
                        mdl_margin = cfg_data[swmn_pkg::HEIGHT_BITS-1:0];
                    swmn_pkg::REG_WIDGET_HEIGHT:
                        mdl_height = cfg_data[swmn_pkg::HEIGHT_BITS-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // receiver: random stalls, one long hold to back the block up, one calm stretch
    int  taken = 0;
    int  hold_left = 0;
    bit  held = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            taken++;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!held && taken >= HOLD_AT)
        begin
            held = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (taken >= CALM_FROM && taken < CALM_TO)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 31);
    end

    // watchdog: cycles in a row with no word and no write moving
    int quiet = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("tb_sliding_window_minmax_normalizer failed");
            $finish;
        end
    end

    // offer one score word, with random idle cycles ahead of it
    task automatic send_score(input logic [swmn_pkg::SCORE_BITS-1:0] s, input logic typed,
                              input result_t want);
        int gap;
        gap = 0;
        if (!(sent >= CALM_FROM && sent < CALM_TO))
            while ($urandom_range(99) < 31)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        preset_fifo[preset_wr % FIFO_DEPTH] = '{typed, want};
        preset_wr++;
        in_valid <= 1'b1;
        score <= s;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // wait until every result word is back and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (exp_wr != exp_rd);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [swmn_pkg::IDX_BITS-1:0] idx,
                             input logic [swmn_pkg::CFG_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_write(input logic [swmn_pkg::IDX_BITS-1:0] idx,
                             input logic [swmn_pkg::CFG_BITS-1:0] data);
        directed[directed_cnt] = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
        directed_cnt++;
    endtask

    task automatic add_score(input logic [swmn_pkg::SCORE_BITS-1:0] s);
        directed[directed_cnt] = '{ROW_SCORE, '0, '0, s, 1'b0, '0};
        directed_cnt++;
    endtask

    task automatic add_typed(input logic [swmn_pkg::SCORE_BITS-1:0] s,
                             input logic [swmn_pkg::SCORE_BITS-1:0] lo,
                             input logic [swmn_pkg::SCORE_BITS-1:0] hi,
                             input int row, input logic flat);
        directed[directed_cnt] = '{ROW_SCORE, '0, '0, s, 1'b1,
                                   '{lo, hi, swmn_pkg::ROW_BITS'(row), flat}};
        directed_cnt++;
    endtask

    initial
    begin
        int phase;
        int i;
        int n;
        int len;
        int pick;
        logic [swmn_pkg::SCORE_BITS-1:0] s;
        logic [swmn_pkg::SCORE_BITS-1:0] base;
        logic [swmn_pkg::SCORE_BITS-1:0] last;
        logic [swmn_pkg::CFG_BITS-1:0] margin;
        logic [swmn_pkg::CFG_BITS-1:0] height;

        // directed table; reset registers are length 16, margin 10, height 100
        add_typed(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 60, 1'b1);  // first word: flat
        add_typed(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 10, 1'b0);  // at max: top row
        add_typed(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 110, 1'b0); // at min: bottom row
        add_typed(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 59, 1'b0);  // just under half
        add_score(32'h0000_0100);
        add_score(32'h1234_5678);
        add_score(32'hFFFF_FFFE);
        add_score(32'h0000_0001);
        // one-entry window is always flat
        add_write(swmn_pkg::REG_WINDOW_LEN, 12'h001);
        add_typed(32'd123, 32'd123, 32'd123, 60, 1'b1);
        add_typed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60, 1'b1);
        // zero length with high data bits set acts as one
        add_write(swmn_pkg::REG_WINDOW_LEN, 12'hF80);
        add_typed(32'd5, 32'd5, 32'd5, 60, 1'b1);
        // oversize length saturates and brings the older scores back
        add_write(swmn_pkg::REG_WINDOW_LEN, 12'h07F);
        add_score(32'd7);
        // height below the floor, margin at its top
        add_write(swmn_pkg::REG_WIDGET_HEIGHT, 12'h000);
        add_write(swmn_pkg::REG_TOP_MARGIN, 12'hFFF);
        add_typed(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4115, 1'b0);
        // largest row the block can give
        add_write(swmn_pkg::REG_WIDGET_HEIGHT, 12'hFFF);
        add_typed(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8190, 1'b0);
        // write to the unused index must leave the height alone
        add_write(REG_UNUSED, 12'hABC);
        add_typed(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8190, 1'b0);
        // height just under and at the floor
        add_write(swmn_pkg::REG_WIDGET_HEIGHT, 12'h013);
        add_score(32'h4000_0000);
        add_write(swmn_pkg::REG_WIDGET_HEIGHT, 12'h014);
        add_score(32'hC000_0000);
        add_write(swmn_pkg::REG_TOP_MARGIN, 12'h000);
        add_write(swmn_pkg::REG_WINDOW_LEN, 12'h002);
        add_score(32'h0000_0000);
        add_score(32'hFFFF_FFFF);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < directed_cnt; n++)
        begin
            if (directed[n].kind == ROW_WRITE)
            begin
                settle();
                write_reg(directed[n].reg_idx, directed[n].reg_data);
            end
            else
                send_score(directed[n].value, directed[n].typed, directed[n].want);
        end

        // random phases, each with fresh register settings
        last = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case ($urandom_range(6))
                0:       len = 0;
                1:       len = 1;
                2:       len = swmn_pkg::MAX_WINDOW;
                3:       len = $urandom_range(127, swmn_pkg::MAX_WINDOW + 1);
                4:       len = $urandom_range(8, 2);
                default: len = $urandom_range(swmn_pkg::MAX_WINDOW, 1);
            endcase
            // bits above the length field are don't-care
            write_reg(swmn_pkg::REG_WINDOW_LEN, {5'($urandom), 7'(len)});
            case ($urandom_range(3))
                0:       margin = '0;
                1:       margin = '1;
                default: margin = swmn_pkg::CFG_BITS'($urandom);
            endcase
            write_reg(swmn_pkg::REG_TOP_MARGIN, margin);
            case ($urandom_range(4))
                0:       height = swmn_pkg::CFG_BITS'($urandom_range(19, 0));
                1:       height = swmn_pkg::CFG_BITS'(20);
                2:       height = '1;
                default: height = swmn_pkg::CFG_BITS'($urandom_range(4095, 21));
            endcase
            write_reg(swmn_pkg::REG_WIDGET_HEIGHT, height);
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, swmn_pkg::CFG_BITS'($urandom));

            // mix of wide, clustered, repeated and extreme scores
            base = $urandom;
            for (i = 0; i < WORDS_PER_PHASE; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    s = $urandom;
                else if (pick < 60)
                    s = base + $urandom_range(3);
                else if (pick < 75)
                    s = last;
                else if (pick < 85)
                    s = $urandom_range(1) ? '1 : '0;
                else
                    s = $urandom >> $urandom_range(31);
                last = s;
                send_score(s, 1'b0, '0);
            end
        end

        // drain: wait for every result word, then DRAIN_CYCLES more
        in_valid <= 1'b0;
        do @(posedge clk); while (exp_wr != exp_rd);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_sliding_window_minmax_normalizer passed");
        else
            $display("tb_sliding_window_minmax_normalizer failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/swmn_pkg.sv
sv/swmn_score_ram.sv
sv/swmn_divider.sv
sv/sliding_window_minmax_normalizer.sv
tb/sv/tb_sliding_window_minmax_normalizer.sv
